// ----- rtl/core/srec_pkg.sv -----
// shared types, character codes and helper functions of the s-record encoder
package srec_pkg;

  // ascii characters of the record text
  localparam logic [7:0] ChS    = 8'h53;
  localparam logic [7:0] ChOne  = 8'h31;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNl   = 8'h0A;

  // number of entries in the front-to-back queue
  localparam int QueueDepth = 2;

  // number of characters in the closing text
  localparam logic [8:0] EndLen = 9'd11;

  // one classified item handed from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic        hdr;
    logic [15:0] addr;
    logic        close;
    logic [7:0]  pad;
    logic [7:0]  csum;
    logic        last;
  } srec_job_t;

  // phase of the character sequencer
  typedef enum logic [2:0] {
    PH_HDR,
    PH_DATA,
    PH_PAD,
    PH_SUM,
    PH_NL,
    PH_END
  } srec_phase_t;

  // upper-case hex digit of one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = 8'h30 + {4'd0, nib};
    end else begin
      res = 8'h37 + {4'd0, nib};
    end
    return res;
  endfunction

  // closing text "S9030000FC" and a newline
  function automatic logic [7:0] end_char(input logic [3:0] idx);
    logic [7:0] res;
    case (idx)
      4'd0:    res = ChS;
      4'd1:    res = ChNine;
      4'd2:    res = 8'h30;
      4'd3:    res = 8'h33;
      4'd4:    res = 8'h30;
      4'd5:    res = 8'h30;
      4'd6:    res = 8'h30;
      4'd7:    res = 8'h30;
      4'd8:    res = 8'h46;
      4'd9:    res = 8'h43;
      default: res = ChNl;
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/core/srec_front.sv -----
// front part: accepts image bytes, tracks record state and classifies each item
module srec_front #(
  parameter int RECORD_BYTES = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              final_byte,
  input  logic              q_full,
  output logic              push,
  output srec_pkg::srec_job_t job
);
  import srec_pkg::*;

  localparam logic [7:0]  RecBytes  = 8'(RECORD_BYTES);
  localparam logic [7:0]  CountByte = 8'(RECORD_BYTES + 3);
  localparam logic [15:0] AddrStep  = 16'(RECORD_BYTES);

  logic [7:0]  bytes_in_record, bytes_in_record_next;
  logic [15:0] record_address, record_address_next;
  logic [7:0]  running_sum, running_sum_next;

  logic       hdr;
  logic [7:0] base_sum;
  logic [7:0] new_sum;
  logic [7:0] bir_inc;
  logic       full_rec;

  // handshake: stall only while the queue has no room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // classify the item against the open record
  always_comb begin
    hdr      = (bytes_in_record == 8'd0);
    base_sum = hdr ? (CountByte + record_address[15:8] + record_address[7:0])
                   : running_sum;
    new_sum  = base_sum + data_byte;
    bir_inc  = bytes_in_record + 8'd1;
    full_rec = (bir_inc >= RecBytes);

    job.data  = data_byte;
    job.hdr   = hdr;
    job.addr  = record_address;
    job.close = full_rec || final_byte;
    job.pad   = full_rec ? 8'd0 : (RecBytes - bir_inc);
    job.csum  = ~new_sum;
    job.last  = final_byte;
  end

  // record state update
  always_comb begin
    bytes_in_record_next = bytes_in_record;
    record_address_next  = record_address;
    running_sum_next     = running_sum;
    if (push) begin
      if (final_byte) begin
        bytes_in_record_next = 8'd0;
        record_address_next  = 16'd0;
        running_sum_next     = 8'd0;
      end else if (full_rec) begin
        bytes_in_record_next = 8'd0;
        record_address_next  = record_address + AddrStep;
        running_sum_next     = 8'd0;
      end else begin
        bytes_in_record_next = bir_inc;
        running_sum_next     = new_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_record <= 8'd0;
      record_address  <= 16'd0;
      running_sum     <= 8'd0;
    end else begin
      bytes_in_record <= bytes_in_record_next;
      record_address  <= record_address_next;
      running_sum     <= running_sum_next;
    end
  end

endmodule

// ----- rtl/core/srec_queue.sv -----
// short queue of classified items between front and back
module srec_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  srec_pkg::srec_job_t push_job,
  input  logic                pop,
  output logic                q_full,
  output logic                q_valid,
  output srec_pkg::srec_job_t head_job
);
  import srec_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  srec_job_t       entries [QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign q_full   = (count == CntW'(QueueDepth));
  assign q_valid  = (count != '0);
  assign head_job = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/srec_back.sv -----
// back part: expands each classified item into characters, one per cycle unless the output stalls
module srec_back #(
  parameter int RECORD_BYTES = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  srec_pkg::srec_job_t head_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_char,
  output logic                run_last
);
  import srec_pkg::*;

  localparam logic [7:0] CountByte = 8'(RECORD_BYTES + 3);

  srec_phase_t ph, ph_next, cur_ph;
  logic        started, started_next;
  logic [8:0]  cnt, cnt_next;

  logic        adv;
  logic        emit;
  logic        phase_end;
  logic        job_done;
  logic [7:0]  char_sel;
  logic [8:0]  pad_chars;
  logic [3:0]  nib;

  assign adv    = !out_valid || !out_stall;
  assign emit   = adv && q_valid;
  assign pop    = emit && job_done;
  assign cur_ph = started ? ph : (head_job.hdr ? PH_HDR : PH_DATA);
  assign pad_chars = {head_job.pad, 1'b0} - 9'd1;

  // next phase and character index
  always_comb begin
    phase_end    = 1'b0;
    job_done     = 1'b0;
    ph_next      = cur_ph;
    case (cur_ph)
      PH_HDR: begin
        phase_end = (cnt == 9'd7);
        ph_next   = PH_DATA;
      end
      PH_DATA: begin
        phase_end = (cnt == 9'd1);
        if (!head_job.close) begin
          job_done = phase_end;
        end else if (head_job.pad != 8'd0) begin
          ph_next = PH_PAD;
        end else begin
          ph_next = PH_SUM;
        end
      end
      PH_PAD: begin
        phase_end = (cnt == pad_chars);
        ph_next   = PH_SUM;
      end
      PH_SUM: begin
        phase_end = (cnt == 9'd1);
        ph_next   = PH_NL;
      end
      PH_NL: begin
        phase_end = 1'b1;
        job_done  = !head_job.last;
        ph_next   = PH_END;
      end
      PH_END: begin
        phase_end = (cnt == EndLen - 9'd1);
        job_done  = phase_end;
      end
      default: begin
        phase_end = 1'b1;
        job_done  = 1'b1;
      end
    endcase

    // stay in the phase until its last character
    if (!phase_end) begin
      ph_next = cur_ph;
    end

    started_next = started;
    cnt_next     = cnt;
    if (emit) begin
      started_next = !job_done;
      cnt_next     = phase_end ? 9'd0 : cnt + 9'd1;
    end
  end

  // character for the current phase and index
  always_comb begin
    nib      = 4'd0;
    char_sel = ChNl;
    case (cur_ph)
      PH_HDR: begin
        case (cnt[2:0])
          3'd0:    nib = 4'd0;
          3'd1:    nib = 4'd0;
          3'd2:    nib = CountByte[7:4];
          3'd3:    nib = CountByte[3:0];
          3'd4:    nib = head_job.addr[15:12];
          3'd5:    nib = head_job.addr[11:8];
          3'd6:    nib = head_job.addr[7:4];
          default: nib = head_job.addr[3:0];
        endcase
        if (cnt[2:0] == 3'd0) begin
          char_sel = ChS;
        end else if (cnt[2:0] == 3'd1) begin
          char_sel = ChOne;
        end else begin
          char_sel = hex_char(nib);
        end
      end
      PH_DATA: begin
        nib      = cnt[0] ? head_job.data[3:0] : head_job.data[7:4];
        char_sel = hex_char(nib);
      end
      PH_PAD: begin
        char_sel = ChZero;
      end
      PH_SUM: begin
        nib      = cnt[0] ? head_job.csum[3:0] : head_job.csum[7:4];
        char_sel = hex_char(nib);
      end
      PH_NL: begin
        char_sel = ChNl;
      end
      PH_END: begin
        char_sel = end_char(cnt[3:0]);
      end
      default: begin
        char_sel = ChNl;
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      ph      <= PH_HDR;
      started <= 1'b0;
      cnt     <= 9'd0;
    end else if (emit) begin
      ph      <= ph_next;
      started <= started_next;
      cnt     <= cnt_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= char_sel;
      run_last <= job_done;
    end
  end

endmodule

// ----- rtl/core/srecord_s1_encoder.sv -----
// S1 record encoder: image bytes in, s-record text out one character per cycle when not stalled
// an item passes through the queue and the output register before its first character appears
// throughput: one output character per cycle while not stalled, set by the character sequencer;
//   a byte gives 2 characters, plus 8 for a record header, 3 to close a record,
//   2 per pad byte and 11 for the closing text after the final byte
// reset: synchronous, clears record state, queue and output register
module srecord_s1_encoder #(
  parameter int RECORD_BYTES = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       run_last
);
  import srec_pkg::*;

  srec_job_t push_job;
  srec_job_t head_job;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_valid;

  // classify incoming items
  srec_front #(
    .RECORD_BYTES(RECORD_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .q_full     (q_full),
    .push       (push),
    .job        (push_job)
  );

  // decouple front and back
  srec_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_full   (q_full),
    .q_valid  (q_valid),
    .head_job (head_job)
  );

  // emit characters
  srec_back #(
    .RECORD_BYTES(RECORD_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .run_last  (run_last)
  );

  // a stalled character holds until it is taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall
    |=> out_valid && $stable(out_char) && $stable(run_last))
    else $error("stalled character changed");

  // a record start is followed by its type digit
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_char == ChS
    |=> out_valid && (out_char == ChOne || out_char == ChNine))
    else $error("record start not followed by type digit");

  // no pop from an empty queue
  assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("queue popped while empty");

  // input stall only when the queue is full
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_full && !$past(rst))
    else $error("input stalled with room in the queue");

endmodule
